### sv/shortest_path_engine_unit_macros.svh
// assertion macros shared by the shortest path engine modules
// expects aclk and aresetn in the scope of each use
`ifndef SHORTEST_PATH_ENGINE_UNIT_MACROS_SVH
`define SHORTEST_PATH_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define SPE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define SPE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/spe_pkg.sv
// shared types and codes of the shortest path engine
// no dependencies
`timescale 1ns / 1ps

package spe_pkg;

    // action codes
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_UNREACH = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  edge_from;
        logic [9:0]  edge_to;
        logic [15:0] edge_weight;
        logic [9:0]  source_node;
        logic [9:0]  target_node;
    } spe_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] distance;
    } spe_out_t;

    // heap command, one transaction per pulse while the heap is idle
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } heap_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic empty;
    } heap_stat_t;

endpackage

### sv/spe_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module spe_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = 4
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/spe_heap.sv
// binary min-heap of (distance, node) with one compare unit and a sequencer
// depends on spe_pkg, spe_ram and the assertion macro header
`timescale 1ns / 1ps
`include "shortest_path_engine_unit_macros.svh"

module spe_heap #(
    parameter int DIST_BITS = 32,
    parameter int NODE_BITS = 10,
    parameter int CAP       = 16385,
    parameter int IDX_BITS  = 15
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  spe_pkg::heap_cmd_t     cmd,
    input  logic [DIST_BITS-1:0]   push_dist,
    input  logic [NODE_BITS-1:0]   push_node,
    output spe_pkg::heap_stat_t    stat,
    output logic [DIST_BITS-1:0]   top_dist,
    output logic [NODE_BITS-1:0]   top_node
);

    localparam int IW = DIST_BITS + NODE_BITS;
    localparam int CW = IDX_BITS + 1;

    typedef enum logic [3:0] {
        H_IDLE, H_UP, H_UP_CMP, H_POP_RD1, H_POP_LAST,
        H_DN, H_DN_C1, H_DN_C2, H_DN_C3
    } hstate_t;

    hstate_t             state_reg, state_next;
    logic [IDX_BITS-1:0] size_reg, size_next;
    logic [IDX_BITS-1:0] i_reg, i_next;
    logic [IW-1:0]       item_reg, item_next;
    logic [IW-1:0]       cand_reg, cand_next;
    logic [IDX_BITS-1:0] cidx_reg, cidx_next;
    logic [IW-1:0]       top_reg, top_next;
    logic                done_reg, done_next;

    logic                ram_we;
    logic [IDX_BITS-1:0] ram_waddr, ram_raddr;
    logic [IW-1:0]       ram_wdata, ram_rdata;
    logic [IW-1:0]       cmp_a, cmp_b;
    logic                lt;
    logic [IDX_BITS-1:0] parent;
    logic [CW-1:0]       child, child1;

    spe_ram #(
        .WIDTH    (IW),
        .DEPTH    (CAP),
        .ADDR_BITS(IDX_BITS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // index arithmetic and the shared compare, dist then node
    assign parent = (i_reg - IDX_BITS'(1)) >> 1;
    assign child  = {i_reg, 1'b1};
    assign child1 = child + CW'(1);
    assign lt     = cmp_a < cmp_b;

    // sequencer
    always_comb begin
        state_next = state_reg;
        size_next  = size_reg;
        i_next     = i_reg;
        item_next  = item_reg;
        cand_next  = cand_reg;
        cidx_next  = cidx_reg;
        top_next   = top_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = i_reg;
        ram_wdata  = item_reg;
        ram_raddr  = '0;
        cmp_a      = item_reg;
        cmp_b      = ram_rdata;
        case (state_reg)
            H_IDLE: begin
                if (cmd.clear) begin
                    size_next = '0;
                end else if (cmd.push) begin
                    if (size_reg != IDX_BITS'(CAP)) begin
                        item_next  = {push_dist, push_node};
                        i_next     = size_reg;
                        size_next  = size_reg + IDX_BITS'(1);
                        state_next = H_UP;
                    end else begin
                        done_next = 1'b1;
                    end
                end else if (cmd.pop) begin
                    ram_raddr  = '0;
                    state_next = H_POP_RD1;
                end
            end
            H_UP: begin
                if (i_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = H_IDLE;
                    done_next  = 1'b1;
                end else begin
                    ram_raddr  = parent;
                    state_next = H_UP_CMP;
                end
            end
            H_UP_CMP: begin
                cmp_a = item_reg;
                cmp_b = ram_rdata;
                ram_we = 1'b1;
                if (lt) begin
                    ram_wdata  = ram_rdata;
                    i_next     = parent;
                    state_next = H_UP;
                end else begin
                    state_next = H_IDLE;
                    done_next  = 1'b1;
                end
            end
            H_POP_RD1: begin
                top_next   = ram_rdata;
                ram_raddr  = size_reg - IDX_BITS'(1);
                size_next  = size_reg - IDX_BITS'(1);
                state_next = H_POP_LAST;
            end
            H_POP_LAST: begin
                item_next = ram_rdata;
                if (size_reg == '0) begin
                    state_next = H_IDLE;
                    done_next  = 1'b1;
                end else begin
                    i_next     = '0;
                    state_next = H_DN;
                end
            end
            H_DN: begin
                if (child < {1'b0, size_reg}) begin
                    ram_raddr  = child[IDX_BITS-1:0];
                    state_next = H_DN_C1;
                end else begin
                    ram_we     = 1'b1;
                    state_next = H_IDLE;
                    done_next  = 1'b1;
                end
            end
            H_DN_C1: begin
                cand_next  = ram_rdata;
                cidx_next  = child[IDX_BITS-1:0];
                ram_raddr  = child1[IDX_BITS-1:0];
                state_next = H_DN_C2;
            end
            H_DN_C2: begin
                // pick the smaller of the two children
                cmp_a = ram_rdata;
                cmp_b = cand_reg;
                if (child1 < {1'b0, size_reg} && lt) begin
                    cand_next = ram_rdata;
                    cidx_next = cidx_reg + IDX_BITS'(1);
                end
                state_next = H_DN_C3;
            end
            H_DN_C3: begin
                cmp_a  = cand_reg;
                cmp_b  = item_reg;
                ram_we = 1'b1;
                if (lt) begin
                    ram_wdata  = cand_reg;
                    i_next     = cidx_reg;
                    state_next = H_DN;
                end else begin
                    state_next = H_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                state_next = H_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            size_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            size_reg  <= size_next;
            done_reg  <= done_next;
        end
        i_reg    <= i_next;
        item_reg <= item_next;
        cand_reg <= cand_next;
        cidx_reg <= cidx_next;
        top_reg  <= top_next;
    end

    assign stat.idle  = (state_reg == H_IDLE);
    assign stat.done  = done_reg;
    assign stat.empty = (size_reg == '0);
    assign top_dist   = top_reg[IW-1:NODE_BITS];
    assign top_node   = top_reg[NODE_BITS-1:0];

    // checks
    `SPE_ASSERT_IMP(a_no_push_full, state_reg == H_IDLE && cmd.push && !cmd.clear, size_reg != IDX_BITS'(CAP), "heap push while full")
    `SPE_ASSERT_IMP(a_no_pop_empty, state_reg == H_IDLE && cmd.pop && !cmd.push && !cmd.clear, size_reg != '0, "heap pop while empty")
    `SPE_ASSERT_IMP(a_done_idle, done_reg, state_reg == H_IDLE, "heap done outside idle")

endmodule

### sv/shortest_path_engine_unit.sv
// shortest path engine top: edge store, node tables, query sequencer
// depends on spe_pkg, spe_ram, spe_heap and the assertion macro header
//
// channel   direction  handshake               payload
// s_        in         s_valid / s_ready       spe_pkg::spe_in_t
// m_        out        m_valid / m_ready       spe_pkg::spe_out_t
// cfg_      in         cfg_wr_en, no wait      node_count, 11 bits
//
// edge load: head read, edge write and reply, in states S_LOAD_RD, S_LOAD_WR and S_REPLY.
// clear and reset: sweep over every node_first_edge entry, no input taken.
// query: node table sweep and the source push, then heap pops and a heap push per
//   relaxed edge, each heap operation stepping through the single heap ram port.
// a result waits in the output register while the next transaction is taken.
`timescale 1ns / 1ps
`include "shortest_path_engine_unit_macros.svh"

module shortest_path_engine_unit #(
    parameter int MAX_NODES     = 1024,
    parameter int MAX_EDGES     = 16384,
    parameter int WEIGHT_BITS   = 16,
    parameter int DISTANCE_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [10:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  spe_pkg::spe_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output spe_pkg::spe_out_t  m_data
);

    localparam int NB  = $clog2(MAX_NODES);
    localparam int EB  = $clog2(MAX_EDGES + 1);
    localparam int EAB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int HB  = $clog2(MAX_EDGES + 2);
    localparam int DB  = DISTANCE_BITS;
    localparam int WB  = WEIGHT_BITS;
    localparam int EWB = NB + WB + EB;
    localparam int SW  = ((DB > WB) ? DB : WB) + 1;
    localparam logic [EB-1:0] NULL_LINK = EB'(MAX_EDGES);
    localparam logic [NB-1:0] LAST_NODE = NB'(MAX_NODES - 1);
    localparam logic [10:0]   CNT_RESET = (MAX_NODES > 1024) ? 11'd1024 : 11'(MAX_NODES);

    typedef enum logic [4:0] {
        S_SWEEP_FIRST, S_IDLE, S_LOAD_RD, S_LOAD_WR, S_SWEEP_NODE,
        S_QPUSH, S_QPUSH_W, S_POP, S_POP_W, S_U_RD, S_U_CHK,
        S_E_RD, S_E_DATA, S_W_CHK, S_W_PUSH_W, S_REPLY
    } state_t;

    state_t            state_reg, state_next;
    logic [10:0]       node_count_reg, node_count_next;
    logic [EB-1:0]     edges_reg, edges_next;
    spe_pkg::spe_in_t  in_reg, in_next;
    logic [NB-1:0]     sweep_reg, sweep_next;
    logic              reply_clr_reg, reply_clr_next;
    logic [1:0]        status_reg, status_next;
    logic [DB-1:0]     dist_res_reg, dist_res_next;
    logic [EB-1:0]     link_reg, link_next;
    logic [NB-1:0]     w_reg, w_next;
    logic [DB-1:0]     nd_reg, nd_next;
    logic              m_valid_reg, m_valid_next;
    spe_pkg::spe_out_t m_data_reg, m_data_next;

    // ram ports
    logic            fe_we;
    logic [NB-1:0]   fe_waddr, fe_raddr;
    logic [EB-1:0]   fe_wdata, fe_rdata;
    logic            ed_we;
    logic [EAB-1:0]  ed_waddr, ed_raddr;
    logic [EWB-1:0]  ed_wdata, ed_rdata;
    logic            ns_we;
    logic [NB-1:0]   ns_waddr, ns_raddr;
    logic [DB+1:0]   ns_wdata, ns_rdata;

    // heap
    spe_pkg::heap_cmd_t  h_cmd;
    spe_pkg::heap_stat_t h_stat;
    logic [DB-1:0]       h_push_dist, h_top_dist;
    logic [NB-1:0]       h_push_node, h_top_node;

    // decoded fields
    logic [NB-1:0]   from_n, to_n, src_n, dst_n;
    logic [WB-1:0]   weight_w;
    logic [31:0]     weight32;
    logic [NB-1:0]   e_to;
    logic [WB-1:0]   e_cost;
    logic [EB-1:0]   e_next;
    logic [SW-1:0]   sum;
    logic [DB-1:0]   nd_sat;
    logic            ld_ok, q_ok;
    logic            reply_go;

    function automatic logic [NB-1:0] to_node(input logic [9:0] id);
        logic [31:0] wide;
        wide = 32'(id);
        return wide[NB-1:0];
    endfunction

    function automatic logic [10:0] clamp_count(input logic [10:0] v);
        logic [10:0] r;
        r = v;
        if (v == 11'd0) begin
            r = 11'd1;
        end else if (32'(v) > MAX_NODES) begin
            r = CNT_RESET;
        end
        return r;
    endfunction

    spe_ram #(.WIDTH(EB), .DEPTH(MAX_NODES), .ADDR_BITS(NB)) u_first_ram (
        .aclk(aclk), .we(fe_we), .waddr(fe_waddr), .wdata(fe_wdata),
        .raddr(fe_raddr), .rdata(fe_rdata)
    );

    spe_ram #(.WIDTH(EWB), .DEPTH(MAX_EDGES), .ADDR_BITS(EAB)) u_edge_ram (
        .aclk(aclk), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
        .raddr(ed_raddr), .rdata(ed_rdata)
    );

    spe_ram #(.WIDTH(DB + 2), .DEPTH(MAX_NODES), .ADDR_BITS(NB)) u_node_ram (
        .aclk(aclk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
        .raddr(ns_raddr), .rdata(ns_rdata)
    );

    spe_heap #(
        .DIST_BITS(DB),
        .NODE_BITS(NB),
        .CAP      (MAX_EDGES + 1),
        .IDX_BITS (HB)
    ) u_heap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (h_cmd),
        .push_dist(h_push_dist),
        .push_node(h_push_node),
        .stat     (h_stat),
        .top_dist (h_top_dist),
        .top_node (h_top_node)
    );

    // field decode
    assign from_n   = to_node(in_reg.edge_from);
    assign to_n     = to_node(in_reg.edge_to);
    assign src_n    = to_node(in_reg.source_node);
    assign dst_n    = to_node(in_reg.target_node);
    assign weight32 = 32'(in_reg.edge_weight);
    assign weight_w = weight32[WB-1:0];
    assign e_to     = ed_rdata[EWB-1 -: NB];
    assign e_cost   = ed_rdata[EB+WB-1:EB];
    assign e_next   = ed_rdata[EB-1:0];

    assign ld_ok = ({1'b0, s_data.edge_from} < node_count_reg)
                && ({1'b0, s_data.edge_to} < node_count_reg);
    assign q_ok  = ({1'b0, s_data.source_node} < node_count_reg)
                && ({1'b0, s_data.target_node} < node_count_reg);

    // saturating adder for edge relaxation
    assign sum    = SW'(h_top_dist) + SW'(e_cost);
    assign nd_sat = (|sum[SW-1:DB]) ? '1 : sum[DB-1:0];

    assign s_ready  = (state_reg == S_IDLE);
    assign reply_go = (state_reg == S_REPLY) && (!m_valid_reg || m_ready);

    // query, load and clear sequencer
    always_comb begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        edges_next      = edges_reg;
        in_next         = in_reg;
        sweep_next      = sweep_reg;
        reply_clr_next  = reply_clr_reg;
        status_next     = status_reg;
        dist_res_next   = dist_res_reg;
        link_next       = link_reg;
        w_next          = w_reg;
        nd_next         = nd_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        fe_we           = 1'b0;
        fe_waddr        = sweep_reg;
        fe_wdata        = NULL_LINK;
        fe_raddr        = from_n;
        ed_we           = 1'b0;
        ed_waddr        = edges_reg[EAB-1:0];
        ed_wdata        = {to_n, weight_w, fe_rdata};
        ed_raddr        = link_reg[EAB-1:0];
        ns_we           = 1'b0;
        ns_waddr        = sweep_reg;
        ns_wdata        = {(sweep_reg == src_n), 1'b0, {DB{1'b0}}};
        ns_raddr        = h_top_node;
        h_cmd           = '0;
        h_push_dist     = nd_reg;
        h_push_node     = w_reg;

        if (cfg_wr_en) begin
            node_count_next = clamp_count(cfg_wr_data);
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_SWEEP_FIRST: begin
                fe_we = 1'b1;
                sweep_next = sweep_reg + NB'(1);
                if (sweep_reg == LAST_NODE) begin
                    edges_next = '0;
                    state_next = reply_clr_reg ? S_REPLY : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    in_next       = s_data;
                    status_next   = spe_pkg::ST_OK;
                    dist_res_next = '0;
                    sweep_next    = '0;
                    case (s_data.action)
                        spe_pkg::ACT_LOAD: begin
                            if (!ld_ok) begin
                                status_next = spe_pkg::ST_RANGE;
                                state_next  = S_REPLY;
                            end else if (edges_reg == NULL_LINK) begin
                                status_next = spe_pkg::ST_FULL;
                                state_next  = S_REPLY;
                            end else begin
                                state_next = S_LOAD_RD;
                            end
                        end
                        spe_pkg::ACT_QUERY: begin
                            if (!q_ok) begin
                                status_next = spe_pkg::ST_RANGE;
                                state_next  = S_REPLY;
                            end else begin
                                state_next = S_SWEEP_NODE;
                            end
                        end
                        spe_pkg::ACT_CLEAR: begin
                            reply_clr_next = 1'b1;
                            state_next     = S_SWEEP_FIRST;
                        end
                        default: begin
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end
            S_LOAD_RD: begin
                fe_raddr   = from_n;
                state_next = S_LOAD_WR;
            end
            S_LOAD_WR: begin
                // new edge goes to the head of its start node's chain
                ed_we      = 1'b1;
                fe_we      = 1'b1;
                fe_waddr   = from_n;
                fe_wdata   = edges_reg;
                edges_next = edges_reg + EB'(1);
                state_next = S_REPLY;
            end
            S_SWEEP_NODE: begin
                // reset reached and done flags, source marked reached at zero
                ns_we       = 1'b1;
                h_cmd.clear = 1'b1;
                sweep_next  = sweep_reg + NB'(1);
                if (sweep_reg == LAST_NODE) begin
                    state_next = S_QPUSH;
                end
            end
            S_QPUSH: begin
                h_cmd.push  = 1'b1;
                h_push_dist = '0;
                h_push_node = src_n;
                state_next  = S_QPUSH_W;
            end
            S_QPUSH_W: begin
                if (h_stat.done) begin
                    state_next = S_POP;
                end
            end
            S_POP: begin
                if (h_stat.empty) begin
                    status_next   = spe_pkg::ST_UNREACH;
                    dist_res_next = '0;
                    state_next    = S_REPLY;
                end else begin
                    h_cmd.pop  = 1'b1;
                    state_next = S_POP_W;
                end
            end
            S_POP_W: begin
                if (h_stat.done) begin
                    state_next = S_U_RD;
                end
            end
            S_U_RD: begin
                ns_raddr   = h_top_node;
                fe_raddr   = h_top_node;
                state_next = S_U_CHK;
            end
            S_U_CHK: begin
                // stale entries are skipped, otherwise mark done, then reply on the target or expand
                if (ns_rdata[DB]) begin
                    state_next = S_POP;
                end else begin
                    ns_we    = 1'b1;
                    ns_waddr = h_top_node;
                    ns_wdata = {ns_rdata[DB+1], 1'b1, ns_rdata[DB-1:0]};
                    if (h_top_node == dst_n) begin
                        status_next   = spe_pkg::ST_OK;
                        dist_res_next = h_top_dist;
                        state_next    = S_REPLY;
                    end else begin
                        link_next  = fe_rdata;
                        state_next = S_E_RD;
                    end
                end
            end
            S_E_RD: begin
                if (link_reg == NULL_LINK) begin
                    state_next = S_POP;
                end else begin
                    ed_raddr   = link_reg[EAB-1:0];
                    state_next = S_E_DATA;
                end
            end
            S_E_DATA: begin
                w_next     = e_to;
                nd_next    = nd_sat;
                link_next  = e_next;
                ns_raddr   = e_to;
                state_next = S_W_CHK;
            end
            S_W_CHK: begin
                // relax when unreached or strictly better
                if (!ns_rdata[DB+1] || ns_rdata[DB-1:0] > nd_reg) begin
                    ns_we      = 1'b1;
                    ns_waddr   = w_reg;
                    ns_wdata   = {1'b1, ns_rdata[DB], nd_reg};
                    h_cmd.push = 1'b1;
                    state_next = S_W_PUSH_W;
                end else begin
                    state_next = S_E_RD;
                end
            end
            S_W_PUSH_W: begin
                if (h_stat.done) begin
                    state_next = S_E_RD;
                end
            end
            S_REPLY: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_data_next.status   = status_reg;
                    m_data_next.distance = 32'(dist_res_reg);
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_SWEEP_FIRST;
            node_count_reg <= CNT_RESET;
            edges_reg      <= '0;
            sweep_reg      <= '0;
            reply_clr_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            edges_reg      <= edges_next;
            sweep_reg      <= sweep_next;
            reply_clr_reg  <= reply_clr_next;
            m_valid_reg    <= m_valid_next;
        end
        in_reg       <= in_next;
        status_reg   <= status_next;
        dist_res_reg <= dist_res_next;
        link_reg     <= link_next;
        w_reg        <= w_next;
        nd_reg       <= nd_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `SPE_ASSERT_IMP(a_edge_bound, 1'b1, edges_reg <= NULL_LINK, "edge count beyond store")
    `SPE_ASSERT_IMP(a_load_room, state_reg == S_LOAD_WR, edges_reg != NULL_LINK, "write when full")
    `SPE_ASSERT_IMP(a_heap_cmd_idle, h_cmd.push || h_cmd.pop, h_stat.idle, "heap command while busy")
    `SPE_ASSERT_NXT(a_reply_out, reply_go, m_valid_reg, "result not presented")

endmodule

### bench/shortest_path_engine_unit_tb.sv
// testbench for the shortest path engine: directed and random graph tests
// depends on spe_pkg and shortest_path_engine_unit; predicts each result from its own graph copy
`timescale 1ns / 1ps

module shortest_path_engine_unit_tb;

    localparam int NODES = 1024;
    localparam int EDGES = 16384;
    localparam logic [63:0] DIST_SAT = 64'hFFFF_FFFF;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [10:0]       cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    spe_pkg::spe_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    spe_pkg::spe_out_t m_data;

    // graph copy kept by the bench
    int          node_limit;
    int          link_to[EDGES];
    logic [15:0] link_cost[EDGES];
    int          link_next[EDGES];
    int          chain_head[NODES];
    int          edges_held;
    // search scratch
    logic [63:0] path_len[NODES];
    bit          seen[NODES];
    bit          settled[NODES];

    spe_pkg::spe_out_t expected_results[$];
    bit          idle_on = 1'b1;
    int          mismatches = 0;
    int          results_seen = 0;
    int          loads_sent = 0;
    int          queries_sent = 0;
    int          others_sent = 0;
    int          ok_paths = 0;
    int          unreachable_seen = 0;

    shortest_path_engine_unit u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // empty the edge store copy
    function automatic void drop_all_edges();
        for (int i = 0; i < NODES; i++) begin
            chain_head[i] = -1;
        end
        edges_held = 0;
    endfunction

    // dijkstra over the copied chains, saturating sums
    function automatic spe_pkg::spe_out_t shortest_distance(int src, int dst);
        spe_pkg::spe_out_t r;
        int open_nodes[$];
        int k;
        int u;
        int e;
        int w;
        logic [63:0] nd;
        r = '0;
        for (int i = 0; i < NODES; i++) begin
            seen[i] = 1'b0;
            settled[i] = 1'b0;
        end
        seen[src] = 1'b1;
        path_len[src] = '0;
        open_nodes = {open_nodes, src};
        while (open_nodes.size() > 0) begin
            k = 0;
            for (int i = 1; i < open_nodes.size(); i++) begin
                if (path_len[open_nodes[i]] < path_len[open_nodes[k]] ||
                    (path_len[open_nodes[i]] == path_len[open_nodes[k]] &&
                     open_nodes[i] < open_nodes[k])) begin
                    k = i;
                end
            end
            u = open_nodes[k];
            open_nodes.delete(k);
            settled[u] = 1'b1;
            if (u == dst) begin
                r.status = spe_pkg::ST_OK;
                r.distance = path_len[u][31:0];
                return r;
            end
            e = chain_head[u];
            while (e >= 0) begin
                w = link_to[e];
                nd = path_len[u] + 64'(link_cost[e]);
                if (nd > DIST_SAT) begin
                    nd = DIST_SAT;
                end
                if (!settled[w] && (!seen[w] || path_len[w] > nd)) begin
                    if (!seen[w]) begin
                        open_nodes = {open_nodes, w};
                    end
                    seen[w] = 1'b1;
                    path_len[w] = nd;
                end
                e = link_next[e];
            end
        end
        r.status = spe_pkg::ST_UNREACH;
        return r;
    endfunction

    // expected result of one transaction, updates the graph copy
    function automatic spe_pkg::spe_out_t engine_result(spe_pkg::spe_in_t it);
        spe_pkg::spe_out_t r;
        r = '0;
        case (it.action)
            spe_pkg::ACT_LOAD: begin
                if (int'(it.edge_from) >= node_limit || int'(it.edge_to) >= node_limit) begin
                    r.status = spe_pkg::ST_RANGE;
                end else if (edges_held >= EDGES) begin
                    r.status = spe_pkg::ST_FULL;
                end else begin
                    link_to[edges_held] = int'(it.edge_to);
                    link_cost[edges_held] = it.edge_weight;
                    link_next[edges_held] = chain_head[it.edge_from];
                    chain_head[it.edge_from] = edges_held;
                    edges_held++;
                end
            end
            spe_pkg::ACT_QUERY: begin
                if (int'(it.source_node) >= node_limit ||
                    int'(it.target_node) >= node_limit) begin
                    r.status = spe_pkg::ST_RANGE;
                end else begin
                    r = shortest_distance(int'(it.source_node), int'(it.target_node));
                end
            end
            spe_pkg::ACT_CLEAR: begin
                drop_all_edges();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // one input transaction with optional leading gap
    task automatic send_item(input spe_pkg::spe_in_t it);
        bit taken;
        spe_pkg::spe_out_t r;
        if (idle_on && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        r = engine_result(it);
        expected_results = {expected_results, r};
        case (it.action)
            spe_pkg::ACT_LOAD: loads_sent++;
            spe_pkg::ACT_QUERY: begin
                queries_sent++;
                if (r.status == spe_pkg::ST_OK) ok_paths++;
                if (r.status == spe_pkg::ST_UNREACH) unreachable_seen++;
            end
            default: others_sent++;
        endcase
    endtask

    task automatic send_fields(input logic [1:0] act, input int a, input int b,
                               input int wgt, input int src, input int dst);
        spe_pkg::spe_in_t it;
        it.action = act;
        it.edge_from = 10'(a);
        it.edge_to = 10'(b);
        it.edge_weight = 16'(wgt);
        it.source_node = 10'(src);
        it.target_node = 10'(dst);
        send_item(it);
    endtask

    // stop sending and wait for every result plus the clear sweep
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
    endtask

    task automatic set_node_count(input logic [10:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (v == 11'd0) node_limit = 1;
        else if (int'(v) > NODES) node_limit = NODES;
        else node_limit = int'(v);
    endtask

    // result check, sampled mid-cycle ahead of the accepting edge
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result status %0d distance %0d",
                                               m_data.status, m_data.distance);
            end else begin
                spe_pkg::spe_out_t e;
                e = expected_results.pop_front();
                if (m_data.status !== e.status || m_data.distance !== e.distance) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected status %0d distance %0d, got %0d %0d",
                                 e.status, e.distance, m_data.status, m_data.distance);
                    end
                end
            end
        end
    end

    // result side stalls
    always @(posedge aclk) begin
        m_ready <= !(idle_on && $urandom_range(99) < 21);
    end

    // extremes, every action and the named corner cases
    task automatic test_directed();
        send_fields(spe_pkg::ACT_QUERY, 0, 0, 0, 0, 0);
        send_fields(spe_pkg::ACT_QUERY, 0, 0, 0, 0, 1);
        send_fields(spe_pkg::ACT_LOAD, 0, 1, 0, 0, 0);
        send_fields(spe_pkg::ACT_LOAD, 1, 1023, 65535, 0, 0);
        send_fields(spe_pkg::ACT_LOAD, 1023, 512, 1, 0, 0);
        send_fields(spe_pkg::ACT_LOAD, 0, 1023, 65535, 0, 0);
        send_fields(spe_pkg::ACT_LOAD, 512, 0, 7, 0, 0);
        send_fields(spe_pkg::ACT_QUERY, 1023, 1023, 65535, 0, 512);
        send_fields(spe_pkg::ACT_QUERY, 0, 0, 0, 512, 1023);
        send_fields(spe_pkg::ACT_SPARE, 1023, 1023, 65535, 1023, 1023);
        send_fields(spe_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
        send_fields(spe_pkg::ACT_QUERY, 0, 0, 0, 0, 512);
        send_fields(spe_pkg::ACT_LOAD, 2, 600, 3, 0, 0);
        send_fields(spe_pkg::ACT_LOAD, 600, 3, 4, 0, 0);
        drain();
        // edges past the lowered count are still walked
        set_node_count(11'd4);
        send_fields(spe_pkg::ACT_QUERY, 0, 0, 0, 2, 3);
        send_fields(spe_pkg::ACT_LOAD, 5, 0, 1, 0, 0);
        send_fields(spe_pkg::ACT_LOAD, 0, 4, 1, 0, 0);
        send_fields(spe_pkg::ACT_QUERY, 0, 0, 0, 0, 7);
        send_fields(spe_pkg::ACT_QUERY, 0, 0, 0, 7, 0);
        drain();
        // zero count is taken as one
        set_node_count(11'd0);
        send_fields(spe_pkg::ACT_LOAD, 0, 0, 9, 0, 0);
        send_fields(spe_pkg::ACT_QUERY, 0, 0, 0, 0, 0);
        send_fields(spe_pkg::ACT_QUERY, 0, 0, 0, 0, 1);
        send_fields(spe_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
        drain();
        set_node_count(11'h7FF);
    endtask

    // random small graphs over a pool of node ids, several counts
    task automatic test_random_graphs();
        logic [10:0] counts[5] = '{11'd8, 11'd1024, 11'd32, 11'd3, 11'd1024};
        int pool[12];
        int pick;
        spe_pkg::spe_in_t it;
        for (int ph = 0; ph < 5; ph++) begin
            set_node_count(counts[ph]);
            for (int i = 0; i < 12; i++) begin
                pool[i] = int'($urandom_range(node_limit - 1));
            end
            pool[0] = node_limit - 1;
            send_fields(spe_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
            for (int n = 0; n < 220; n++) begin
                it = spe_pkg::spe_in_t'(58'({$urandom, $urandom}));
                pick = int'($urandom_range(99));
                if (pick < 50) it.action = spe_pkg::ACT_LOAD;
                else if (pick < 88) it.action = spe_pkg::ACT_QUERY;
                else if (pick < 91) it.action = spe_pkg::ACT_CLEAR;
                else if (pick < 94) it.action = spe_pkg::ACT_SPARE;
                if ($urandom_range(9) != 0) begin
                    it.edge_from = 10'(pool[$urandom_range(11)]);
                    it.edge_to = 10'(pool[$urandom_range(11)]);
                    it.source_node = 10'(pool[$urandom_range(11)]);
                    it.target_node = 10'(pool[$urandom_range(11)]);
                end
                if (edges_held > 70 && it.action == spe_pkg::ACT_LOAD) begin
                    it.action = spe_pkg::ACT_CLEAR;
                end
                // no stalls in the first half of the second wide phase
                idle_on = (ph != 4 || n > 110);
                send_item(it);
            end
            drain();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        node_limit = NODES;
        drop_all_edges();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (1200) @(posedge aclk);
        test_directed();
        test_random_graphs();
        drain();
        $display("covered %0d loads, %0d queries (%0d ok, %0d unreachable), %0d other",
                 loads_sent, queries_sent, ok_paths, unreachable_seen, others_sent);
        $display("node counts 0, 3, 4, 8, 32, 1024 and 2047; %0d results checked",
                 results_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #80_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### shortest_path_engine_unit.f
+incdir+sv
sv/spe_pkg.sv
sv/spe_ram.sv
sv/spe_heap.sv
sv/shortest_path_engine_unit.sv
bench/shortest_path_engine_unit_tb.sv
